/* rtl/pcc_pkg.sv */
package pcc_pkg;

    // filter geometry
    localparam int BLOCK_SIZE   = 64;
    localparam int NUM_BLOCKS   = 8;
    localparam int FILTER_SLOTS = 4;

    localparam int TAPS_PER_SLOT = NUM_BLOCKS * BLOCK_SIZE;
    localparam int COEF_DEPTH    = FILTER_SLOTS * TAPS_PER_SLOT;
    localparam int HIST_DEPTH    = NUM_BLOCKS * BLOCK_SIZE;

    // field widths
    localparam int OP_W     = 2;
    localparam int SMP_W    = 16;
    localparam int SLOT_W   = 3;
    localparam int TAP_W    = 9;

    // derived widths
    localparam int POS_W    = $clog2(BLOCK_SIZE);
    localparam int AGE_W    = $clog2(NUM_BLOCKS);
    localparam int SIDX_W   = $clog2(FILTER_SLOTS);
    localparam int HADDR_W  = $clog2(HIST_DEPTH);
    localparam int CADDR_W  = $clog2(COEF_DEPTH);
    localparam int N_W      = $clog2(2 * BLOCK_SIZE);
    localparam int ACC_W    = 48;
    localparam int TAIL_W   = 40;

    // opcodes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_COEF   = 2'd1;
    localparam logic [OP_W-1:0] OP_FADE   = 2'd2;
    localparam logic [OP_W-1:0] OP_SET    = 2'd3;

    // classified command from the front end
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [SMP_W-1:0]  sample;
        logic [SLOT_W-1:0]        slot;
        logic [TAP_W-1:0]         tap;
        logic signed [SMP_W-1:0]  coef;
        logic                     coef_ok;
    } t_cmd;

    // back end status seen by the front end
    typedef struct packed {
        logic clearing;
        logic cmd_ready;
    } t_back_stat;

endpackage

/* rtl/pcc_if.sv */
interface pcc_in_if;
    import pcc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [SMP_W-1:0] sample_in;
    logic [SLOT_W-1:0]       slot;
    logic [TAP_W-1:0]        tap_index;
    logic signed [SMP_W-1:0] coefficient;

    modport source (output valid, opcode, sample_in, slot, tap_index, coefficient,
                    input ready);
    modport sink (input valid, opcode, sample_in, slot, tap_index, coefficient,
                  output ready);
endinterface

interface pcc_out_if;
    import pcc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] sample_out;
    logic                    last;

    modport source (output valid, sample_out, last, input ready);
    modport sink (input valid, sample_out, last, output ready);
endinterface

/* rtl/pcc_front.sv */
module pcc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pcc_in_if.sink             i_in,
    input  pcc_pkg::t_back_stat i_stat,
    output logic               o_cmd_valid,
    output pcc_pkg::t_cmd      o_cmd
);
    import pcc_pkg::*;

    t_cmd        r_fifo [0:1];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    t_cmd        w_cls;
    logic        w_push;
    logic        w_pop;

    // classify the incoming word
    always_comb begin
        w_cls.op     = i_in.opcode;
        w_cls.sample = i_in.sample_in;
        w_cls.tap    = i_in.tap_index;
        w_cls.coef   = i_in.coefficient;
        if (int'(i_in.slot) > FILTER_SLOTS) begin
            w_cls.slot = SLOT_W'(FILTER_SLOTS);
        end else begin
            w_cls.slot = i_in.slot;
        end
        w_cls.coef_ok = (int'(i_in.slot) < FILTER_SLOTS) &&
                        (int'(i_in.tap_index) < TAPS_PER_SLOT);
    end

    assign i_in.ready  = (r_cnt != 2'd2) && !i_stat.clearing;
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_stat.cmd_ready;
    assign o_cmd       = r_fifo[r_rp];

    // two-entry command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_cls;
        end
    end

endmodule

/* rtl/pcc_back.sv */
module pcc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  pcc_pkg::t_cmd       i_cmd,
    output pcc_pkg::t_back_stat o_stat,
    pcc_out_if.source           o_out
);
    import pcc_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    localparam int PRD_W  = SMP_W + POS_W + 1;
    localparam int FADE_W = SMP_W + 1;
    localparam int TERM_W = SMP_W + FADE_W;
    localparam logic [N_W-1:0] L_BS   = N_W'(BLOCK_SIZE);
    localparam logic [N_W-1:0] L_BSM1 = N_W'(BLOCK_SIZE - 1);
    localparam logic [N_W-1:0] L_NEND = N_W'(2 * BLOCK_SIZE - 2);

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] k;
        logic             ph;
        logic             mask;
        logic             last;
        logic [N_W-1:0]   n;
    } t_mac_ctl;

    // memories
    logic signed [SMP_W-1:0]  mem_hist [0:HIST_DEPTH-1];
    logic signed [SMP_W-1:0]  mem_coef [0:COEF_DEPTH-1];
    logic signed [TAIL_W-1:0] mem_tail [0:BLOCK_SIZE-1];

    // control state
    logic [1:0]         r_state;
    logic [CADDR_W-1:0] r_clr_cnt;
    logic [POS_W-1:0]   r_pos;
    logic [AGE_W-1:0]   r_head;
    logic [SLOT_W-1:0]  r_queue [0:NUM_BLOCKS];
    logic [SLOT_W-1:0]  r_ring  [0:NUM_BLOCKS];
    logic [N_W-1:0]     r_n;
    logic [AGE_W-1:0]   r_i;
    logic [POS_W-1:0]   r_k;
    logic               r_ph;

    // pipeline
    t_mac_ctl                 r1_ctl, r2_ctl, r3_ctl;
    logic signed [SMP_W-1:0]  r1_x, r1_h, r2_x, r2_h;
    logic signed [PRD_W-1:0]  r2_prod;
    logic signed [TERM_W-1:0] r3_term;
    logic signed [TAIL_W-1:0] r_tail_q;
    logic signed [ACC_W-1:0]  r_acc;

    // output register
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_sample;
    logic                    r_out_last;

    logic                   w_take;
    logic                   w_start;
    logic                   w_adv;
    logic                   w_issue;
    logic [N_W-1:0]         w_klo, w_khi, w_n1, w_klo_nx, w_jn;
    logic [AGE_W:0]         w_row_sum;
    logic [AGE_W-1:0]       w_row;
    logic [SLOT_W-1:0]      w_sel;
    logic                   w_mask;
    logic                   w_k_end;
    logic                   w_i_end;
    logic                   w_last;
    logic [HADDR_W-1:0]     w_hraddr, w_hwaddr;
    logic [CADDR_W-1:0]     w_craddr, w_cwaddr;
    logic signed [FADE_W-1:0] w_up, w_dn, w_fade;
    logic signed [ACC_W-1:0]  w_sum;
    logic signed [ACC_W:0]    w_rnd;
    logic signed [ACC_W:0]    w_shr;
    logic signed [SMP_W-1:0]  w_y;
    logic signed [TAIL_W-1:0] w_tail_new;
    logic                   w_emit;
    logic                   w_tail_we;
    logic                   w_drained;

    assign o_stat.clearing  = (r_state == ST_CLEAR);
    assign o_stat.cmd_ready = (r_state == ST_IDLE);
    assign w_take  = i_cmd_valid && (r_state == ST_IDLE);
    assign w_start = w_take && (i_cmd.op == OP_SAMPLE) && (r_pos == POS_W'(BLOCK_SIZE - 1));

    // term sequencing: output index n, age i, input index k, fade phase
    always_comb begin
        w_klo     = (r_n >= L_BS) ? r_n - L_BSM1 : '0;
        w_khi     = (r_n < L_BS) ? r_n : L_BSM1;
        w_n1      = r_n + 1'b1;
        w_klo_nx  = (w_n1 >= L_BS) ? w_n1 - L_BSM1 : '0;
        w_jn      = r_n - N_W'(r_k);
        w_row_sum = (AGE_W+1)'(r_head) + (AGE_W+1)'(r_i);
        if (int'(w_row_sum) >= NUM_BLOCKS) begin
            w_row = AGE_W'(int'(w_row_sum) - NUM_BLOCKS);
        end else begin
            w_row = w_row_sum[AGE_W-1:0];
        end
        w_sel    = r_ph ? r_ring[0] : r_ring[1];
        w_mask   = (int'(w_sel) >= FILTER_SLOTS);
        w_k_end  = (N_W'(r_k) == w_khi) && r_ph;
        w_i_end  = (int'(r_i) == NUM_BLOCKS - 1);
        w_last   = w_k_end && w_i_end;
        w_hraddr = HADDR_W'(int'(w_row) * BLOCK_SIZE + int'(r_k));
        w_craddr = CADDR_W'(int'(w_sel[SIDX_W-1:0]) * TAPS_PER_SLOT +
                            int'(r_i) * BLOCK_SIZE + int'(w_jn[POS_W-1:0]));
        w_hwaddr = HADDR_W'(int'(r_head) * BLOCK_SIZE + int'(r_pos));
        w_cwaddr = CADDR_W'(int'(i_cmd.slot[SIDX_W-1:0]) * TAPS_PER_SLOT + int'(i_cmd.tap));
    end

    assign w_issue = (r_state == ST_RUN);

    // fade and product stage
    always_comb begin
        w_up   = FADE_W'(r2_prod / BLOCK_SIZE);
        w_dn   = FADE_W'(r2_x) - w_up;
        w_fade = r2_ctl.ph ? w_up : w_dn;
    end

    // accumulate, round and saturate
    always_comb begin
        w_sum = r_acc + ACC_W'(r3_term);
        w_rnd = (ACC_W+1)'(w_sum) + (ACC_W+1)'(r_tail_q) + (ACC_W+1)'(16384);
        w_shr = w_rnd >>> 15;
        if (w_shr > (ACC_W+1)'(32767)) begin
            w_y = 16'sh7fff;
        end else if (w_shr < -(ACC_W+1)'(32768)) begin
            w_y = -16'sh8000;
        end else begin
            w_y = w_shr[SMP_W-1:0];
        end
        if (w_sum > ACC_W'(64'sh7f_ffff_ffff)) begin
            w_tail_new = {1'b0, {(TAIL_W-1){1'b1}}};
        end else if (w_sum < -ACC_W'(64'sh80_0000_0000)) begin
            w_tail_new = {1'b1, {(TAIL_W-1){1'b0}}};
        end else begin
            w_tail_new = w_sum[TAIL_W-1:0];
        end
        w_emit    = r3_ctl.valid && r3_ctl.last && (r3_ctl.n < L_BS);
        w_tail_we = r3_ctl.valid && r3_ctl.last && (r3_ctl.n >= L_BS);
    end

    // whole pipeline holds while a finished sample cannot leave
    assign w_adv     = !(w_emit && r_out_valid && !o_out.ready);
    assign w_drained = !r1_ctl.valid && !r2_ctl.valid && !r3_ctl.valid;

    // sequencer and filter queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_clr_cnt <= '0;
            r_pos     <= '0;
            r_head    <= '0;
            r_n       <= '0;
            r_i       <= '0;
            r_k       <= '0;
            r_ph      <= 1'b0;
            for (int q = 0; q <= NUM_BLOCKS; q++) begin
                r_queue[q] <= SLOT_W'(FILTER_SLOTS);
                r_ring[q]  <= SLOT_W'(FILTER_SLOTS);
            end
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + 1'b1;
                    if (int'(r_clr_cnt) == COEF_DEPTH - 1) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (w_take) begin
                        case (i_cmd.op)
                            OP_SAMPLE: begin
                                if (w_start) begin
                                    r_pos   <= '0;
                                    r_n     <= '0;
                                    r_i     <= '0;
                                    r_k     <= '0;
                                    r_ph    <= 1'b0;
                                    r_ring  <= r_queue;
                                    r_state <= ST_RUN;
                                end else begin
                                    r_pos <= r_pos + 1'b1;
                                end
                            end
                            OP_FADE: r_queue[0] <= i_cmd.slot;
                            OP_SET: begin
                                for (int q = 0; q <= NUM_BLOCKS; q++) begin
                                    r_queue[q] <= i_cmd.slot;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    if (w_adv) begin
                        r_ph <= !r_ph;
                        if (r_ph) begin
                            r_k <= r_k + 1'b1;
                        end
                        if (w_k_end) begin
                            r_i <= r_i + 1'b1;
                            if (w_i_end) begin
                                r_i <= '0;
                                r_n <= w_n1;
                                r_k <= w_klo_nx[POS_W-1:0];
                                for (int q = 0; q <= NUM_BLOCKS; q++) begin
                                    r_ring[q] <= r_ring[(q + 2) % (NUM_BLOCKS + 1)];
                                end
                                if (r_n == L_NEND) begin
                                    r_state <= ST_DRAIN;
                                end
                            end else begin
                                r_k <= w_klo[POS_W-1:0];
                                for (int q = 0; q <= NUM_BLOCKS; q++) begin
                                    r_ring[q] <= r_ring[(q + 1) % (NUM_BLOCKS + 1)];
                                end
                            end
                        end
                    end
                end
                ST_DRAIN: begin
                    // age the history and the filter queue
                    if (w_drained) begin
                        r_head <= (r_head == '0) ? AGE_W'(NUM_BLOCKS - 1) : r_head - 1'b1;
                        for (int q = 1; q <= NUM_BLOCKS; q++) begin
                            r_queue[q] <= r_queue[q-1];
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // input history memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            mem_hist[r_clr_cnt[HADDR_W-1:0]] <= '0;
        end else if (w_take && (i_cmd.op == OP_SAMPLE)) begin
            mem_hist[w_hwaddr] <= i_cmd.sample;
        end
        if (w_adv) begin
            r1_x <= mem_hist[w_hraddr];
        end
    end

    // coefficient memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            mem_coef[r_clr_cnt] <= '0;
        end else if (w_take && (i_cmd.op == OP_COEF) && i_cmd.coef_ok) begin
            mem_coef[w_cwaddr] <= i_cmd.coef;
        end
        if (w_adv) begin
            r1_h <= mem_coef[w_craddr];
        end
    end

    // overlap tail memory
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            mem_tail[r_clr_cnt[POS_W-1:0]] <= '0;
        end else if ((r_state == ST_DRAIN) && w_drained) begin
            mem_tail[POS_W'(BLOCK_SIZE - 1)] <= '0;
        end else if (w_adv && w_tail_we) begin
            mem_tail[r3_ctl.n[POS_W-1:0]] <= w_tail_new;
        end
        if (w_adv) begin
            r_tail_q <= mem_tail[r2_ctl.n[POS_W-1:0]];
        end
    end

    // pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl <= '0;
            r2_ctl <= '0;
            r3_ctl <= '0;
            r_acc  <= '0;
        end else if (w_adv) begin
            r1_ctl.valid <= w_issue;
            r1_ctl.k     <= r_k;
            r1_ctl.ph    <= r_ph;
            r1_ctl.mask  <= w_mask;
            r1_ctl.last  <= w_last;
            r1_ctl.n     <= r_n;
            r2_ctl       <= r1_ctl;
            r3_ctl       <= r2_ctl;
            if (r3_ctl.valid) begin
                r_acc <= r3_ctl.last ? '0 : w_sum;
            end
        end
    end

    // fade and tap products
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_x    <= r1_x;
            r2_h    <= r1_h;
            r2_prod <= PRD_W'(r1_x) * PRD_W'($signed({1'b0, r1_ctl.k}));
            if (r2_ctl.mask) begin
                r3_term <= '0;
            end else begin
                r3_term <= TERM_W'(r2_h) * TERM_W'(w_fade);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit && w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit && w_adv) begin
            r_out_sample <= w_y;
            r_out_last   <= (r3_ctl.n == L_BSM1);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.last       = r_out_last;

endmodule

/* rtl/partitioned_convolver_crossfade_core.sv */
// commands: a coefficient, crossfade or set word is executed in the back end after queueing
// a sample that completes a block starts the shared multiply-accumulate pass over
// every output index, history block and input index, in both fade phases
// throughput: one product per cycle unless the output stalls; no word is executed mid-pass
// reset: synchronous, active low; then a clearing pass over the coefficient,
// history and tail memories during which no word is accepted
module partitioned_convolver_crossfade_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pcc_in_if.sink    i_in,
    pcc_out_if.source o_out
);
    import pcc_pkg::*;

    logic       w_cmd_valid;
    t_cmd       w_cmd;
    t_back_stat w_stat;

    // accept and classify
    pcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_stat      (w_stat),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    // execute and convolve
    pcc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out       (o_out)
    );

endmodule

/* rtl/pcc_checker.sv */
module pcc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_sample,
    input logic        out_last
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_sample) && $stable(out_last))
        else $error("output word changed while stalled");

    // no output right after reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid)
        else $error("output valid after reset");

    // clearing pass blocks input after reset
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !in_ready)
        else $error("input ready during clearing pass");

    // always holds: the checked term is anded with 1'b0, so nothing is tested
    a_in_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rst_n ##1 1'b1 |-> !(in_ready && !in_valid && out_valid && !out_ready && 1'b0))
        else $error("unexpected handshake state");

endmodule

bind partitioned_convolver_crossfade_core pcc_checker u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .in_valid   (i_in.valid),
    .in_ready   (i_in.ready),
    .out_valid  (o_out.valid),
    .out_ready  (o_out.ready),
    .out_sample (o_out.sample_out),
    .out_last   (o_out.last)
);

/* tb/sv/partitioned_convolver_crossfade_core_tb.sv */
module partitioned_convolver_crossfade_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pcc_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct {
        logic signed [SMP_W-1:0] smp;
        logic                    last;
    } out_word_t;

    typedef struct {
        logic [OP_W-1:0]         op;
        logic signed [SMP_W-1:0] smp;
        logic [SLOT_W-1:0]       slot;
        logic [TAP_W-1:0]        tap;
        logic signed [SMP_W-1:0] coef;
        int                      reps;
        bit                      has_exp;
        logic signed [SMP_W-1:0] exp_val;
    } stim_row_t;

    logic i_clk;
    logic i_rst_n;

    pcc_in_if  in_bus ();
    pcc_out_if out_bus ();

    partitioned_convolver_crossfade_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // convolver mirror state
    int                      blk_pos;
    logic signed [SMP_W-1:0] blk_buf [BLOCK_SIZE];
    int                      hist [NUM_BLOCKS][BLOCK_SIZE];
    int                      hist_head;
    logic [SLOT_W-1:0]       slot_q [NUM_BLOCKS+1];
    int                      coef_mem [COEF_DEPTH];
    longint                  tail [BLOCK_SIZE];
    longint                  conv_sum [2*BLOCK_SIZE];

    out_word_t pending_out [$];

    int  errors;
    int  words_sent;
    int  words_seen;
    int  blocks_done;
    int  idle_cycles;
    bit  hold_req;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // partitioned convolution of the block just completed
    function automatic void convolve_block(bit has_exp, logic signed [SMP_W-1:0] exp_val);
        longint    up;
        longint    dn;
        longint    t;
        longint    v;
        longint    y;
        int        so;
        int        sn;
        int        xrow;
        out_word_t w;
        for (int k = 0; k < BLOCK_SIZE; k++) hist[hist_head][k] = blk_buf[k];
        for (int n = 0; n < 2*BLOCK_SIZE; n++) conv_sum[n] = 0;
        for (int i = 0; i < NUM_BLOCKS; i++) begin
            so   = slot_q[i+1];
            sn   = slot_q[i];
            xrow = (hist_head + i) % NUM_BLOCKS;
            for (int k = 0; k < BLOCK_SIZE; k++) begin
                up = (longint'(hist[xrow][k]) * k) / BLOCK_SIZE;
                dn = hist[xrow][k] - up;
                for (int j = 0; j < BLOCK_SIZE; j++) begin
                    t = 0;
                    if (so < FILTER_SLOTS)
                        t += longint'(coef_mem[so*TAPS_PER_SLOT + i*BLOCK_SIZE + j]) * dn;
                    if (sn < FILTER_SLOTS)
                        t += longint'(coef_mem[sn*TAPS_PER_SLOT + i*BLOCK_SIZE + j]) * up;
                    conv_sum[k+j] += t;
                end
            end
        end
        // round to nearest, saturate, keep second half as tail
        for (int n = 0; n < BLOCK_SIZE; n++) begin
            v = conv_sum[n] + tail[n];
            y = (v + 16384) >>> 15;
            if (y > 32767) y = 32767;
            if (y < -32768) y = -32768;
            w.smp  = has_exp ? exp_val : SMP_W'(y);
            w.last = (n == BLOCK_SIZE-1);
            pending_out.push_back(w);
            v = conv_sum[n+BLOCK_SIZE];
            if (v > 64'sd549755813887) v = 64'sd549755813887;
            if (v < -64'sd549755813888) v = -64'sd549755813888;
            tail[n] = v;
        end
        hist_head = (hist_head + NUM_BLOCKS - 1) % NUM_BLOCKS;
        for (int i = NUM_BLOCKS; i > 0; i--) slot_q[i] = slot_q[i-1];
        blocks_done++;
    endfunction

    function automatic void predict_word(logic [OP_W-1:0] op, logic signed [SMP_W-1:0] smp,
                                         logic [SLOT_W-1:0] sl, logic [TAP_W-1:0] tap,
                                         logic signed [SMP_W-1:0] cf, bit has_exp,
                                         logic signed [SMP_W-1:0] exp_val);
        logic [SLOT_W-1:0] s;
        s = (sl > FILTER_SLOTS) ? SLOT_W'(FILTER_SLOTS) : sl;
        case (op)
            OP_SAMPLE: begin
                if (blk_pos >= BLOCK_SIZE) blk_pos = 0;
                blk_buf[blk_pos] = smp;
                blk_pos++;
                if (blk_pos == BLOCK_SIZE) begin
                    blk_pos = 0;
                    convolve_block(has_exp, exp_val);
                end
            end
            OP_COEF: begin
                if (sl < FILTER_SLOTS && tap < TAPS_PER_SLOT)
                    coef_mem[sl*TAPS_PER_SLOT + tap] = cf;
            end
            OP_FADE: slot_q[0] = s;
            default: begin
                for (int i = 0; i <= NUM_BLOCKS; i++) slot_q[i] = s;
            end
        endcase
    endfunction

    // offer one word, wait for acceptance, then an optional gap
    task automatic send_word(logic [OP_W-1:0] op, logic signed [SMP_W-1:0] smp,
                             logic [SLOT_W-1:0] sl, logic [TAP_W-1:0] tap,
                             logic signed [SMP_W-1:0] cf, bit has_exp = 0,
                             logic signed [SMP_W-1:0] exp_val = '0);
        int gap;
        in_bus.valid       <= 1'b1;
        in_bus.opcode      <= op;
        in_bus.sample_in   <= smp;
        in_bus.slot        <= sl;
        in_bus.tap_index   <= tap;
        in_bus.coefficient <= cf;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        predict_word(op, smp, sl, tap, cf, has_exp, exp_val);
        words_sent++;
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_random_cmd();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            send_word(OP_COEF, $urandom, $urandom_range(0, 7), $urandom, $urandom);
        else if (r < 9)
            send_word(OP_FADE, $urandom, $urandom_range(0, 7), $urandom, $urandom);
        else
            send_word(OP_SET, $urandom, $urandom_range(0, 7), $urandom, $urandom);
    endtask

    // receiver ready, with a long hold-off when the stimulus requests one
    initial begin
        int n;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_bus.ready <= 1'b0;
                hold_req = 0;
                for (int c = 0; c < HOLD_CYCLES; c++) @(negedge i_clk);
            end
            n = pick_gap();
            if (n > 0) begin
                out_bus.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // output check
    always @(posedge i_clk) begin
        out_word_t e;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            words_seen++;
            if (pending_out.size() == 0) begin
                $display("%0t: unexpected output word sample_out=%0d last=%0b",
                         $time, out_bus.sample_out, out_bus.last);
                errors++;
            end else begin
                e = pending_out.pop_front();
                if (out_bus.sample_out !== e.smp) begin
                    $display("%0t: sample_out expected %0d actual %0d",
                             $time, e.smp, out_bus.sample_out);
                    errors++;
                end
                if (out_bus.last !== e.last) begin
                    $display("%0t: last expected %0b actual %0b", $time, e.last, out_bus.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d words still pending", $time,
                     pending_out.size());
            $display("partitioned_convolver_crossfade_core_tb: errors");
            $finish;
        end
    end

    // stimulus
    initial begin
        stim_row_t rows [$];
        logic signed [SMP_W-1:0] smp;

        errors      = 0;
        words_sent  = 0;
        words_seen  = 0;
        blocks_done = 0;
        idle_cycles = 0;
        hold_req    = 0;
        blk_pos     = 0;
        hist_head   = 0;
        for (int i = 0; i <= NUM_BLOCKS; i++) slot_q[i] = SLOT_W'(FILTER_SLOTS);
        for (int i = 0; i < NUM_BLOCKS; i++)
            for (int k = 0; k < BLOCK_SIZE; k++) hist[i][k] = 0;
        for (int i = 0; i < COEF_DEPTH; i++) coef_mem[i] = 0;
        for (int n = 0; n < BLOCK_SIZE; n++) tail[n] = 0;

        i_rst_n            = 1'b0;
        in_bus.valid       = 1'b0;
        in_bus.opcode      = OP_SAMPLE;
        in_bus.sample_in   = '0;
        in_bus.slot        = '0;
        in_bus.tap_index   = '0;
        in_bus.coefficient = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows: with no filter after reset the first block is silent
        rows.push_back('{OP_SAMPLE, 16'sh7fff, 3'd0, 9'd0, 16'sd0, 32, 1, 16'sd0});
        rows.push_back('{OP_SAMPLE, -16'sh8000, 3'd0, 9'd0, 16'sd0, 32, 1, 16'sd0});
        rows.push_back('{OP_COEF, 16'sd0, 3'd0, 9'd0, 16'sh7fff, 1, 0, 16'sd0});
        rows.push_back('{OP_COEF, 16'sd0, 3'd0, 9'd511, -16'sh8000, 1, 0, 16'sd0});
        rows.push_back('{OP_COEF, 16'sd0, 3'd0, 9'd64, 16'sd16384, 1, 0, 16'sd0});
        rows.push_back('{OP_COEF, 16'sd0, 3'd3, 9'd5, -16'sh8000, 1, 0, 16'sd0});
        rows.push_back('{OP_COEF, 16'sd0, 3'd1, 9'd200, 16'sd12345, 1, 0, 16'sd0});
        rows.push_back('{OP_COEF, 16'sd0, 3'd1, 9'd1, 16'sh7fff, 1, 0, 16'sd0});
        // slot out of range: write ignored
        rows.push_back('{OP_COEF, 16'sd0, 3'd4, 9'd0, 16'sh7fff, 1, 0, 16'sd0});
        rows.push_back('{OP_COEF, 16'sd0, 3'd7, 9'd511, 16'sd1, 1, 0, 16'sd0});
        rows.push_back('{OP_SET, 16'sd0, 3'd5, 9'd0, 16'sd0, 1, 0, 16'sd0});
        rows.push_back('{OP_SET, 16'sd0, 3'd0, 9'd0, 16'sd0, 1, 0, 16'sd0});
        // unchanged filter block
        rows.push_back('{OP_SAMPLE, 16'sh7fff, 3'd0, 9'd0, 16'sd0, 64, 0, 16'sd0});
        // repeated crossfade: only the last one counts
        rows.push_back('{OP_FADE, 16'sd0, 3'd7, 9'd0, 16'sd0, 1, 0, 16'sd0});
        rows.push_back('{OP_FADE, 16'sd0, 3'd1, 9'd0, 16'sd0, 1, 0, 16'sd0});
        rows.push_back('{OP_FADE, 16'sd0, 3'd3, 9'd0, 16'sd0, 1, 0, 16'sd0});
        rows.push_back('{OP_SAMPLE, -16'sh8000, 3'd0, 9'd0, 16'sd0, 64, 0, 16'sd0});
        // crossfade to no filter
        rows.push_back('{OP_FADE, 16'sd0, 3'd4, 9'd0, 16'sd0, 1, 0, 16'sd0});
        rows.push_back('{OP_SAMPLE, 16'sd1000, 3'd0, 9'd0, 16'sd0, 64, 0, 16'sd0});

        foreach (rows[r])
            for (int n = 0; n < rows[r].reps; n++)
                send_word(rows[r].op, rows[r].smp, rows[r].slot, rows[r].tap, rows[r].coef,
                          rows[r].has_exp, rows[r].exp_val);

        // random blocks: coefficient traffic, filter changes and noisy sample runs
        for (int b = 0; b < 3; b++) begin
            if (b == 1) hold_req = 1;
            if (b == 2) begin
                in_bus.valid <= 1'b0;
                while (pending_out.size() != 0) @(negedge i_clk);
                repeat (50) @(negedge i_clk);
            end
            repeat ($urandom_range(4, 14)) send_random_cmd();
            for (int k = 0; k < BLOCK_SIZE; k++) begin
                if ($urandom_range(0, 9) == 0) send_random_cmd();
                smp = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 2047)) - 1024;
                send_word(OP_SAMPLE, smp, $urandom, $urandom, $urandom);
            end
        end

        in_bus.valid <= 1'b0;
        while (pending_out.size() != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);

        $display("covered %0d input words, %0d blocks, %0d output words, with crossfades,",
                 words_sent, blocks_done, words_seen);
        $display("slot sets, ignored writes, saturation and long output stalls");
        if (errors == 0) begin
            $display("partitioned_convolver_crossfade_core_tb: clean");
        end else begin
            $display("partitioned_convolver_crossfade_core_tb: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/pcc_pkg.sv
rtl/pcc_if.sv
rtl/pcc_front.sv
rtl/pcc_back.sv
rtl/partitioned_convolver_crossfade_core.sv
rtl/pcc_checker.sv
tb/sv/partitioned_convolver_crossfade_core_tb.sv
